/* rtl/ltl_pkg.sv */
// Shared types, constants and character class helpers for the lambda token lexer.
// Used by lambda_token_lexer_core; no dependencies.

package ltl_pkg;

   localparam int LTL_POSITION_BITS = 16;
   localparam int CP_BITS           = 21;
   localparam int BC_BITS           = 3;
   localparam int OUT_BITS          = 16;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

   // character constants
   localparam logic [CP_BITS-1:0] CH_NUL       = 21'h000000;
   localparam logic [CP_BITS-1:0] CH_TAB       = 21'h000009;
   localparam logic [CP_BITS-1:0] CH_LF        = 21'h00000A;
   localparam logic [CP_BITS-1:0] CH_CR        = 21'h00000D;
   localparam logic [CP_BITS-1:0] CH_SPACE     = 21'h000020;
   localparam logic [CP_BITS-1:0] CH_HASH      = 21'h000023;
   localparam logic [CP_BITS-1:0] CH_DOLLAR    = 21'h000024;
   localparam logic [CP_BITS-1:0] CH_LPAR      = 21'h000028;
   localparam logic [CP_BITS-1:0] CH_RPAR      = 21'h000029;
   localparam logic [CP_BITS-1:0] CH_DOT       = 21'h00002E;
   localparam logic [CP_BITS-1:0] CH_DIGIT_0   = 21'h000030;
   localparam logic [CP_BITS-1:0] CH_DIGIT_9   = 21'h000039;
   localparam logic [CP_BITS-1:0] CH_SEMI      = 21'h00003B;
   localparam logic [CP_BITS-1:0] CH_EQUALS    = 21'h00003D;
   localparam logic [CP_BITS-1:0] CH_AT        = 21'h000040;
   localparam logic [CP_BITS-1:0] CH_UPPER_A   = 21'h000041;
   localparam logic [CP_BITS-1:0] CH_UPPER_Z   = 21'h00005A;
   localparam logic [CP_BITS-1:0] CH_BACKSLASH = 21'h00005C;
   localparam logic [CP_BITS-1:0] CH_UNDERLINE = 21'h00005F;
   localparam logic [CP_BITS-1:0] CH_LOWER_A   = 21'h000061;
   localparam logic [CP_BITS-1:0] CH_LOWER_Z   = 21'h00007A;
   localparam logic [CP_BITS-1:0] CH_LAMBDA    = 21'h0003BB;

   typedef enum logic [2:0] {
      TOK_EOL    = 3'd0,
      TOK_IDENT  = 3'd1,
      TOK_LAMBDA = 3'd2,
      TOK_LPAR   = 3'd3,
      TOK_RPAR   = 3'd4,
      TOK_BODY   = 3'd5,
      TOK_EOF    = 3'd6,
      TOK_ERROR  = 3'd7
   } token_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_IDENT   = 4'b0010,
      MODE_EOL     = 4'b0100,
      MODE_COMMENT = 4'b1000
   } lex_mode_type;

   typedef struct packed {
      logic                last;
      logic [OUT_BITS-1:0] column;
      logic [OUT_BITS-1:0] line;
      logic [OUT_BITS-1:0] length;
      logic [OUT_BITS-1:0] start;
      token_kind_type      kind;
   } lex_token_type;

   function automatic logic is_letter(input logic [CP_BITS-1:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             c == CH_UNDERLINE || c == CH_DOLLAR || c == CH_AT;
   endfunction

   function automatic logic is_wordchar(input logic [CP_BITS-1:0] c);
      return is_letter(c) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
   endfunction

   function automatic logic is_lineend(input logic [CP_BITS-1:0] c);
      return c == CH_SEMI || c == CH_CR || c == CH_LF;
   endfunction

endpackage

/* rtl/lambda_token_lexer_core.sv */
// Lambda token lexer: one decoded code point in per item, tokens out.
// An item is registered on accept and then stepped into the result queue; its first token
// shows on rsp_ from there. Throughput: one item per cycle while two queue slots are free,
// bounded by the one-token-per-cycle result queue (4 entries) when items yield two tokens.
// Reset (synchronous, active high): mode idle, offset 0, row and column 1, queue empty.
// Depends on ltl_pkg.

module lambda_token_lexer_core
   import ltl_pkg::*;
#(
   parameter int POSITION_BITS = LTL_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // code_point[20:0], byte_count[23:21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // start_offset[15:0], byte_length[31:16],
                                    // line_number[47:32], column_number[63:48]
   output logic [2:0]  rsp_tuser,   // token_kind[2:0]
   output logic        rsp_tlast    // last_of_run
);

   localparam int P      = POSITION_BITS;
   localparam int QA     = $clog2(QUEUE_DEPTH);
   localparam int QC     = QA + 1;

   typedef logic [P-1:0] pos_type;

   function automatic pos_type sat_add(input pos_type a, input logic [BC_BITS-1:0] b);
      logic [P:0] s;
      s = {1'b0, a} + (P+1)'(b);
      return s[P] ? {P{1'b1}} : s[P-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] clamp_out(input pos_type v);
      logic [P+OUT_BITS-1:0] w;
      w = (P+OUT_BITS)'(v);
      return (w > (P+OUT_BITS)'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
   endfunction

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [CP_BITS-1:0]  cp_ff;
   logic [BC_BITS-1:0]  bc_ff;

   // lexer state
   lex_mode_type mode_ff, mode_in;
   pos_type      pos_ff, pos_in;
   pos_type      row_ff, row_in;
   pos_type      col_ff, col_in;
   pos_type      pstart_ff, pstart_in;
   pos_type      plen_ff, plen_in;
   pos_type      prow_ff, prow_in;
   pos_type      pcol_ff, pcol_in;

   // result queue
   lex_token_type queue_ff [QUEUE_DEPTH];
   logic [QA-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC-1:0] count_ff, count_in;

   logic         pop;
   logic         step_fire;
   logic         req_accept;

   pos_type       cons_pos, cons_row, cons_col;
   logic          flush_v, main_v;
   lex_token_type flush_tok, main_tok, slot0, slot1;
   logic [1:0]    push_n;
   logic          fall;
   lex_token_type head;

   assign pop        = rsp_tvalid && rsp_tready;
   assign step_fire  = in_valid_ff && ((count_ff - QC'(pop)) <= QC'(QUEUE_DEPTH - 2));
   assign req_tready = !in_valid_ff || step_fire;
   assign req_accept = req_tvalid && req_tready;

   // position after consuming the current code point
   always_comb begin
      cons_pos = sat_add(pos_ff, bc_ff);
      if (cp_ff == CH_LF) begin
         cons_row = sat_add(row_ff, BC_BITS'(1));
         cons_col = P'(1);
      end else begin
         cons_row = row_ff;
         cons_col = sat_add(col_ff, BC_BITS'(1));
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      prow_in   = prow_ff;
      pcol_in   = pcol_ff;
      flush_v   = 1'b0;
      main_v    = 1'b0;
      fall      = 1'b0;

      flush_tok.kind   = (mode_ff == MODE_IDENT) ? TOK_IDENT : TOK_EOL;
      flush_tok.start  = clamp_out(pstart_ff);
      flush_tok.length = clamp_out(plen_ff);
      flush_tok.line   = clamp_out(prow_ff);
      flush_tok.column = clamp_out(pcol_ff);
      flush_tok.last   = 1'b0;

      main_tok.kind    = TOK_ERROR;
      main_tok.start   = clamp_out(pos_ff);
      main_tok.length  = OUT_BITS'(bc_ff);
      main_tok.line    = clamp_out(row_ff);
      main_tok.column  = clamp_out(col_ff);
      main_tok.last    = 1'b0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (cp_ff != CH_NUL) begin
               pos_in = cons_pos;
               row_in = cons_row;
               col_in = cons_col;
               if (cp_ff == CH_LF) mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_IDLE;
               fall    = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_wordchar(cp_ff)) begin
               plen_in = sat_add(plen_ff, bc_ff);
               pos_in  = cons_pos;
               row_in  = cons_row;
               col_in  = cons_col;
            end else begin
               flush_v = 1'b1;
               mode_in = MODE_IDLE;
               fall    = 1'b1;
            end
         end
         MODE_EOL: begin
            if (is_lineend(cp_ff)) begin
               plen_in = sat_add(plen_ff, bc_ff);
               pos_in  = cons_pos;
               row_in  = cons_row;
               col_in  = cons_col;
            end else begin
               flush_v = 1'b1;
               mode_in = MODE_IDLE;
               fall    = 1'b1;
            end
         end
         default: fall = 1'b1;
      endcase

      if (fall) begin
         if (cp_ff == CH_SPACE || cp_ff == CH_TAB) begin
            pos_in = cons_pos;
            row_in = cons_row;
            col_in = cons_col;
         end else if (cp_ff == CH_HASH) begin
            pos_in  = cons_pos;
            row_in  = cons_row;
            col_in  = cons_col;
            mode_in = MODE_COMMENT;
         end else if (is_lineend(cp_ff) || is_letter(cp_ff)) begin
            mode_in   = is_letter(cp_ff) ? MODE_IDENT : MODE_EOL;
            pstart_in = pos_ff;
            plen_in   = P'(bc_ff);
            prow_in   = row_ff;
            pcol_in   = col_ff;
            pos_in    = cons_pos;
            row_in    = cons_row;
            col_in    = cons_col;
         end else if (cp_ff == CH_NUL) begin
            main_v          = 1'b1;
            main_tok.kind   = TOK_EOF;
            main_tok.length = '0;
         end else begin
            main_v = 1'b1;
            if (cp_ff == CH_BACKSLASH || cp_ff == CH_LAMBDA) main_tok.kind = TOK_LAMBDA;
            else if (cp_ff == CH_LPAR)                       main_tok.kind = TOK_LPAR;
            else if (cp_ff == CH_RPAR)                       main_tok.kind = TOK_RPAR;
            else if (cp_ff == CH_DOT || cp_ff == CH_EQUALS)  main_tok.kind = TOK_BODY;
            else                                             main_tok.kind = TOK_ERROR;
            pos_in = cons_pos;
            row_in = cons_row;
            col_in = cons_col;
         end
      end

      // pack up to two tokens, final one marked
      slot1      = main_tok;
      slot1.last = 1'b1;
      if (flush_v) begin
         slot0      = flush_tok;
         slot0.last = !main_v;
      end else begin
         slot0      = main_tok;
         slot0.last = 1'b1;
      end
      push_n = {1'b0, flush_v} + {1'b0, main_v};
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)     in_valid_in = 1'b1;
      else if (step_fire) in_valid_in = 1'b0;

      wr_ptr_in = wr_ptr_ff + (step_fire ? QA'(push_n) : QA'(0));
      rd_ptr_in = rd_ptr_ff + QA'(pop);
      count_in  = count_ff + (step_fire ? QC'(push_n) : QC'(0)) - QC'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         row_ff      <= P'(1);
         col_ff      <= P'(1);
         pstart_ff   <= '0;
         plen_ff     <= '0;
         prow_ff     <= P'(1);
         pcol_ff     <= P'(1);
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (step_fire) begin
            mode_ff   <= mode_in;
            pos_ff    <= pos_in;
            row_ff    <= row_in;
            col_ff    <= col_in;
            pstart_ff <= pstart_in;
            plen_ff   <= plen_in;
            prow_ff   <= prow_in;
            pcol_ff   <= pcol_in;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cp_ff <= req_tdata[CP_BITS-1:0];
         bc_ff <= req_tdata[CP_BITS+BC_BITS-1:CP_BITS];
      end
      if (step_fire && push_n != 2'd0) queue_ff[wr_ptr_ff] <= slot0;
      if (step_fire && push_n == 2'd2) queue_ff[wr_ptr_ff + QA'(1)] <= slot1;
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head.last;
   assign rsp_tuser  = head.kind;
   assign rsp_tdata  = {head.column, head.line, head.length, head.start};

   // assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC'(QUEUE_DEPTH))
      else $error("result queue over depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      step_fire |-> (count_in <= QC'(QUEUE_DEPTH)))
      else $error("step pushed into a full queue");

   a_eof_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.kind == TOK_EOF) |-> (head.length == '0 && head.last))
      else $error("eof token with length or not last");

   a_row_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head.line != '0 && head.column != '0))
      else $error("token with zero row or column");

endmodule
